// ----- sv/dpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types, character codes and helper functions for the debug packet
// deframer.
// ----------------------------------------------------------------------------
package dpd_pkg;

	// Framing and signal characters
	localparam logic [7:0] CH_START  = 8'h24;  // '$'
	localparam logic [7:0] CH_END    = 8'h23;  // '#'
	localparam logic [7:0] CH_INT_A  = 8'h02;
	localparam logic [7:0] CH_INT_B  = 8'h03;
	localparam logic [7:0] CH_TRAP   = 8'h05;
	localparam logic [7:0] ACK_GOOD  = 8'h2B;  // '+'
	localparam logic [7:0] ACK_BAD   = 8'h2D;  // '-'

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_SIGNAL  = 2'd2;

	// Signal codes
	localparam logic SIG_INTERRUPT = 1'b0;
	localparam logic SIG_TRAP      = 1'b1;

	// Reset value of the whitespace skip register
	localparam logic SKIP_WS_RESET = 1'b1;

	// Deframer phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HEX_HI  = 2'd2,
		PH_HEX_LO  = 2'd3
	} dpd_phase_t;

	// One result beat
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic       signal_code;
		logic       checksum_good;
		logic [7:0] received_checksum;
		logic [7:0] computed_checksum;
		logic [7:0] ack_byte;
	} dpd_res_t;

	// Space, tab, LF, VT, FF, CR
	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction

	// Hex digit decode: bit 4 flags a bad digit, low nibble is zero then
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [7:0] d;
		d = 8'h00;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			d = b - 8'h30;
			return {1'b0, d[3:0]};
		end
		if ((b >= 8'h61) && (b <= 8'h66)) begin
			d = b - 8'h57;
			return {1'b0, d[3:0]};
		end
		if ((b >= 8'h41) && (b <= 8'h46)) begin
			d = b - 8'h37;
			return {1'b0, d[3:0]};
		end
		return 5'b1_0000;
	endfunction

endpackage

// ----- sv/dpd_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_parse
// Framing state machine: tracks the packet phase, the running checksum and
// the received checksum digits, and forms at most one result per byte.
// ----------------------------------------------------------------------------
module dpd_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic              skip_ws,
	output logic              has_res,
	output dpd_pkg::dpd_res_t res
);
	import dpd_pkg::*;

	dpd_phase_t  phase_q, phase_d;
	logic [7:0]  sum_q;
	logic [3:0]  high_nibble_q;
	logic        hex_error_q;

	logic        drop;
	logic [4:0]  hex;
	logic [7:0]  rx_sum;
	logic        good;

	assign drop   = skip_ws && is_space(rx_byte);
	assign hex    = hex_decode(rx_byte);
	assign rx_sum = {high_nibble_q, hex[3:0]};
	assign good   = !hex_error_q && !hex[4] && (rx_sum == sum_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (!drop) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (rx_byte == CH_START) phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (rx_byte == CH_END) phase_d = PH_HEX_HI;
				end
				PH_HEX_HI: phase_d = PH_HEX_LO;
				PH_HEX_LO: phase_d = PH_IDLE;
				default:   phase_d = PH_IDLE;
			endcase
		end
	end

	// Result forming
	always_comb begin
		has_res = 1'b0;
		res     = '0;
		if (!drop) begin
			unique case (phase_q)
				PH_IDLE: begin
					if ((rx_byte == CH_INT_A) || (rx_byte == CH_INT_B) ||
					    (rx_byte == CH_TRAP)) begin
						has_res         = 1'b1;
						res.kind        = KIND_SIGNAL;
						res.signal_code = (rx_byte == CH_TRAP) ? SIG_TRAP : SIG_INTERRUPT;
					end
				end
				PH_PAYLOAD: begin
					if (rx_byte != CH_END) begin
						has_res          = 1'b1;
						res.kind         = KIND_PAYLOAD;
						res.payload_byte = rx_byte;
					end
				end
				PH_HEX_HI: has_res = 1'b0;
				PH_HEX_LO: begin
					has_res               = 1'b1;
					res.kind              = KIND_END;
					res.checksum_good     = good;
					res.received_checksum = rx_sum;
					res.computed_checksum = sum_q;
					res.ack_byte          = good ? ACK_GOOD : ACK_BAD;
				end
				default: has_res = 1'b0;
			endcase
		end
	end

	// Advance the phase, checksum and digit state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			sum_q         <= '0;
			high_nibble_q <= '0;
			hex_error_q   <= 1'b0;
		end else if (step && !drop) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte == CH_START) begin
						sum_q         <= '0;
						high_nibble_q <= '0;
						hex_error_q   <= 1'b0;
					end
				end
				PH_PAYLOAD: begin
					if (rx_byte != CH_END) sum_q <= sum_q + rx_byte;
				end
				PH_HEX_HI: begin
					high_nibble_q <= hex[3:0];
					if (hex[4]) hex_error_q <= 1'b1;
				end
				default: begin
					sum_q         <= '0;
					high_nibble_q <= '0;
					hex_error_q   <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- sv/debug_packet_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_packet_deframer
// Deframes the remote debug serial protocol byte stream into payload beats,
// packet-end checksum reports and interrupt/trap signal events.
// ----------------------------------------------------------------------------
// Each received byte is captured in an input register, decoded by the
// framing state machine from that register and, if it causes a result,
// lands in the output register. With res_ready held high a byte is
// accepted every clock; the output register lets the next byte enter
// while a result waits.
// Bytes that produce no result ('$', '#', the first checksum digit, skipped
// whitespace, idle noise) are absorbed without a result beat. The skip
// register (reset 1) may only be written while no byte is in flight.
module debug_packet_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic       signal_code,
	output logic       checksum_good,
	output logic [7:0] received_checksum,
	output logic [7:0] computed_checksum,
	output logic [7:0] ack_byte
);
	import dpd_pkg::*;

	logic       skip_ws_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       has_res;
	dpd_res_t   res;
	logic       valid_s2;
	dpd_res_t   res_s2;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_ws_q <= SKIP_WS_RESET;
		end else if (cfg_wr_en) begin
			skip_ws_q <= cfg_wr_data;
		end
	end

	// Stage 1 advances when the output register is free or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || res_ready);
	assign rx_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) byte_s1 <= rx_byte;
	end

	dpd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.rx_byte (byte_s1),
		.skip_ws (skip_ws_q),
		.has_res (has_res),
		.res     (res)
	);

	// Output register: load a new beat, or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= has_res;
		end else if (res_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) res_s2 <= res;
	end

	assign res_valid         = valid_s2;
	assign kind              = res_s2.kind;
	assign payload_byte      = res_s2.payload_byte;
	assign signal_code       = res_s2.signal_code;
	assign checksum_good     = res_s2.checksum_good;
	assign received_checksum = res_s2.received_checksum;
	assign computed_checksum = res_s2.computed_checksum;
	assign ack_byte          = res_s2.ack_byte;

`ifndef ASSERT_OFF
	// Ack byte follows the match flag at packet end
	a_ack_match: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (kind == KIND_END)) |->
		((checksum_good && (ack_byte == ACK_GOOD)) ||
		 (!checksum_good && (ack_byte == ACK_BAD))))
		else $error("ack byte disagrees with checksum flag");

	// Only defined result kinds leave the block
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((kind == KIND_PAYLOAD) || (kind == KIND_END) ||
		               (kind == KIND_SIGNAL)))
		else $error("undefined result kind");

	// A stalled input byte holds until it is decoded
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stage 1 byte lost while stalled");

	// A waiting result is never overwritten
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |-> !adv_s1)
		else $error("output register overwritten while full");
`endif

endmodule

// ----- tb/debug_packet_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_packet_deframer_tb
// Self-checking bench for the debug packet deframer. Bytes go in over the
// rx valid/ready channel. A local deframer model predicts every payload,
// packet-end and signal beat. Each beat taken on the result channel is
// compared field by field with the oldest prediction. Directed frames come
// first, then whitespace handling with skipping turned off, output
// backpressure, and long runs of random packets, signals, noise and broken
// frames. Both channels idle at random.
// ----------------------------------------------------------------------------
module debug_packet_deframer_tb;
	import dpd_pkg::*;

	localparam int SETTLE_CYCLES    = 6;
	localparam int STUCK_LIMIT      = 2000;
	localparam int SINK_HOLD_CYCLES = 150;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       rx_valid    = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte     = 8'h00;
	logic       res_valid;
	logic       res_ready   = 1'b0;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic       signal_code;
	logic       checksum_good;
	logic [7:0] received_checksum;
	logic [7:0] computed_checksum;
	logic [7:0] ack_byte;

	// Local deframer state and register copy
	logic       ws_skip = SKIP_WS_RESET;
	dpd_phase_t frm_phase = PH_IDLE;
	logic [7:0] frm_sum = 8'h00;
	logic [3:0] frm_hi_nib = 4'h0;
	logic       frm_hex_bad = 1'b0;

	dpd_res_t   expected_beats [$];
	int         err_count = 0;
	int         stuck_cycles = 0;
	bit         gaps_on = 1'b0;
	bit         sink_hold_req = 1'b0;

	logic [7:0] ws_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	logic [7:0] sig_chars [3] = '{CH_INT_A, CH_INT_B, CH_TRAP};

	debug_packet_deframer DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.rx_valid          (rx_valid),
		.rx_ready          (rx_ready),
		.rx_byte           (rx_byte),
		.res_valid         (res_valid),
		.res_ready         (res_ready),
		.kind              (kind),
		.payload_byte      (payload_byte),
		.signal_code       (signal_code),
		.checksum_good     (checksum_good),
		.received_checksum (received_checksum),
		.computed_checksum (computed_checksum),
		.ack_byte          (ack_byte)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit is_ws_char(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Bit 4 set means a valid digit, low nibble is its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'b0_0000;
	endfunction

	function automatic bit is_hex_char(input logic [7:0] c);
		logic [4:0] d;
		d = hex_digit(c);
		return d[4];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// Short gaps mostly, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Append one predicted beat at the tail of the queue
	function automatic void add_expected(input dpd_res_t beat);
		expected_beats.insert(expected_beats.size(), beat);
	endfunction

	// Advance the local deframer by one accepted byte and queue its beat
	task automatic deframe_step(input logic [7:0] b);
		dpd_res_t   beat;
		logic [4:0] dig;
		logic [7:0] rx_sum;
		beat = '0;
		if (!(ws_skip && is_ws_char(b))) begin
			case (frm_phase)
				PH_IDLE: begin
					if (b == CH_START) begin
						frm_phase   = PH_PAYLOAD;
						frm_sum     = 8'h00;
						frm_hi_nib  = 4'h0;
						frm_hex_bad = 1'b0;
					end else if (b == CH_INT_A || b == CH_INT_B || b == CH_TRAP) begin
						beat.kind        = KIND_SIGNAL;
						beat.signal_code = (b == CH_TRAP) ? SIG_TRAP : SIG_INTERRUPT;
						add_expected(beat);
					end
				end
				PH_PAYLOAD: begin
					if (b == CH_END) begin
						frm_phase = PH_HEX_HI;
					end else begin
						frm_sum           = frm_sum + b;
						beat.kind         = KIND_PAYLOAD;
						beat.payload_byte = b;
						add_expected(beat);
					end
				end
				PH_HEX_HI: begin
					dig = hex_digit(b);
					if (!dig[4])
						frm_hex_bad = 1'b1;
					frm_hi_nib = dig[3:0];
					frm_phase  = PH_HEX_LO;
				end
				default: begin
					dig = hex_digit(b);
					if (!dig[4])
						frm_hex_bad = 1'b1;
					rx_sum                 = {frm_hi_nib, dig[3:0]};
					beat.kind              = KIND_END;
					beat.checksum_good     = !frm_hex_bad && (rx_sum == frm_sum);
					beat.received_checksum = rx_sum;
					beat.computed_checksum = frm_sum;
					beat.ack_byte          = beat.checksum_good ? ACK_GOOD : ACK_BAD;
					add_expected(beat);
					frm_phase   = PH_IDLE;
					frm_sum     = 8'h00;
					frm_hi_nib  = 4'h0;
					frm_hex_bad = 1'b0;
				end
			endcase
		end
	endtask

	// Offer one byte, hold it until taken, then maybe idle
	task automatic send_byte(input logic [7:0] b);
		int gap;
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		deframe_step(b);
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every predicted beat, then let the pipe empty
	task automatic drain(input int settle);
		rx_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Only called with nothing in flight
	task automatic write_skip(input logic v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		ws_skip = v;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic maybe_ws();
		if (ws_skip && $urandom_range(0, 9) == 0)
			send_byte(ws_chars[$urandom_range(0, 5)]);
	endtask

	// Well-formed frame with random body; checksum mostly right, else wrong or bad digit
	task automatic send_random_packet(output int n);
		int         len;
		int         mode;
		bit         upper;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] ck;
		logic [7:0] hi_c;
		logic [7:0] lo_c;
		len = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
		sum = 8'h00;
		send_byte(CH_START);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			while (b == CH_END || (ws_skip && is_ws_char(b)))
				b = 8'($urandom_range(0, 255));
			maybe_ws();
			send_byte(b);
			sum = sum + b;
		end
		maybe_ws();
		send_byte(CH_END);
		mode  = $urandom_range(0, 19);
		upper = 1'($urandom_range(0, 1));
		ck    = sum;
		if (mode >= 15 && mode < 18)
			ck = sum ^ (8'h01 << $urandom_range(0, 7));
		hi_c = hex_char(ck[7:4], upper);
		lo_c = hex_char(ck[3:0], upper);
		if (mode >= 18) begin
			b = 8'($urandom_range(0, 255));
			while (is_hex_char(b) || (ws_skip && is_ws_char(b)))
				b = 8'($urandom_range(0, 255));
			if (mode == 18)
				hi_c = b;
			else
				lo_c = b;
		end
		send_byte(hi_c);
		maybe_ws();
		send_byte(lo_c);
		n = len + 4;
	endtask

	// Framing-heavy junk: opens, closes and digits in no useful order
	task automatic send_broken_frame(output int n);
		int         len;
		int         r;
		logic [7:0] b;
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 4);
			case (r)
				0: b = CH_START;
				1: b = CH_END;
				2: b = hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
				3: b = sig_chars[$urandom_range(0, 2)];
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
		n = len;
	endtask

	task automatic test_directed_frames();
		// idle noise and all three signal bytes
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_INT_A);
		send_byte(CH_INT_B);
		send_byte(CH_TRAP);
		// start and trap chars as payload, tab and space skipped, good sum 0x28
		send_byte(CH_START);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_START);
		send_byte(CH_TRAP);
		send_byte(8'h09);
		send_byte(CH_END);
		send_byte("2");
		send_byte(8'h20);
		send_byte("8");
		// empty packet
		send_byte(CH_START);
		send_byte(CH_END);
		send_byte("0");
		send_byte("0");
		// bad first digit
		send_byte(CH_START);
		send_byte(CH_END);
		send_byte("g");
		send_byte("0");
		// valid digits in both cases but wrong value
		send_byte(CH_START);
		send_byte("a");
		send_byte(CH_END);
		send_byte("f");
		send_byte("F");
		drain(SETTLE_CYCLES);
	endtask

	task automatic test_whitespace_modes();
		write_skip(1'b0);
		// space dropped in idle, CR and LF as payload, VT as bad second digit
		send_byte(8'h20);
		send_byte(CH_START);
		send_byte(8'h0D);
		send_byte(8'h0A);
		send_byte(CH_END);
		send_byte("1");
		send_byte(8'h0B);
		// FF as bad first digit
		send_byte(CH_START);
		send_byte(CH_END);
		send_byte(8'h0C);
		send_byte("7");
		drain(SETTLE_CYCLES);
		write_skip(1'b1);
	endtask

	task automatic test_output_backpressure();
		int n;
		gaps_on = 1'b0;
		sink_hold_req = 1'b1;
		send_random_packet(n);
		for (int i = 0; i < 30; i++)
			send_byte(8'($urandom_range(0, 255)));
		drain(SETTLE_CYCLES);
	endtask

	task automatic test_random_traffic(input logic skip, input bit idle, input int target);
		int sent;
		int n;
		int r;
		int iter;
		drain(SETTLE_CYCLES);
		write_skip(skip);
		gaps_on = idle;
		sent = 0;
		iter = 0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			n = 0;
			if (r < 70) begin
				send_random_packet(n);
			end else if (r < 80) begin
				send_byte(sig_chars[$urandom_range(0, 2)]);
				n = 1;
			end else if (r < 90) begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_broken_frame(n);
			end
			sent += n;
			iter++;
			// hold the sender until the output side has caught up
			if (iter % 40 == 0)
				drain(0);
		end
		drain(SETTLE_CYCLES);
	endtask

	// Result sink: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				res_ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 99) < 25) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
				res_ready <= 1'b0;
				repeat (n) @(posedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endtask

	// Compare each taken result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		dpd_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat, kind %0h", $time, kind);
				err_count++;
			end else begin
				want = expected_beats.pop_front();
				cmp_field("kind", 8'(want.kind), 8'(kind));
				cmp_field("payload_byte", want.payload_byte, payload_byte);
				cmp_field("signal_code", 8'(want.signal_code), 8'(signal_code));
				cmp_field("checksum_good", 8'(want.checksum_good), 8'(checksum_good));
				cmp_field("received_checksum", want.received_checksum, received_checksum);
				cmp_field("computed_checksum", want.computed_checksum, computed_checksum);
				cmp_field("ack_byte", want.ack_byte, ack_byte);
			end
		end
	end

	// End the run if neither channel moves for too long
	always @(posedge clk) begin : watchdog
		if ((rx_valid && rx_ready) || (res_valid && res_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("debug_packet_deframer_tb: done, errors");
			$finish;
		end
	end

	initial begin : main_seq
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_whitespace_modes();
		test_output_backpressure();
		test_random_traffic(1'b1, 1'b1, 450);
		test_random_traffic(1'b0, 1'b1, 450);
		test_random_traffic(1'b1, 1'b0, 350);
		test_random_traffic(1'b0, 1'b0, 250);
		test_random_traffic(1'b1, 1'b1, 300);
		drain(SETTLE_CYCLES);
		if (err_count == 0)
			$display("debug_packet_deframer_tb: done, clean");
		else
			$display("debug_packet_deframer_tb: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/dpd_pkg.sv
sv/dpd_parse.sv
sv/debug_packet_deframer.sv
tb/debug_packet_deframer_tb.sv
